// File: hw/rtl/base58_encoder_defines.svh
// ---------------------------------------------------------------------------
// Base-58 encoder assertion macros
// Shared concurrent assertion forms used by the encoder checker.
// ---------------------------------------------------------------------------
`ifndef BASE58_ENCODER_DEFINES_SVH
`define BASE58_ENCODER_DEFINES_SVH

// Overlapped implication, sampled on the rising clock, off during reset.
`define B58_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base58 encoder assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define B58_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base58 encoder assertion failed");

`endif

// File: hw/rtl/b58_pkg.sv
// ---------------------------------------------------------------------------
// Base-58 encoder package
// Constants and the alphabet lookup shared by the encoder files.
// ---------------------------------------------------------------------------
package b58_pkg;

  localparam int unsigned CapW = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  localparam int unsigned B58Radix = 58;
  localparam int unsigned DigitW = 6;
  localparam int unsigned CharW = 7;
  localparam int unsigned ByteW = 8;

  // Quotient of a 14-bit value by 58 as (value * DivMul) >> DivShift; exact below 58*256.
  localparam int unsigned CurW = DigitW + ByteW;
  localparam int unsigned ProdW = 29;
  localparam logic [14:0] DivMul = 15'd18079;
  localparam int unsigned DivShift = 20;

  localparam logic [8*58-1:0] Alphabet =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  localparam logic [CharW-1:0] OvfChar = 7'd0;

  function automatic logic [CharW-1:0] b58_char(input logic [DigitW-1:0] digit);
    logic [CharW-1:0] ch;
    ch = '0;
    if (int'(digit) < B58Radix) begin
      ch = Alphabet[8*(B58Radix-1-int'(digit)) +: CharW];
    end
    return ch;
  endfunction

endpackage

// File: hw/rtl/b58_in_if.sv
// ---------------------------------------------------------------------------
// Base-58 byte channel
// Valid/ready channel carrying one input byte and its end-of-string flag.
// ---------------------------------------------------------------------------
interface b58_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/b58_out_if.sv
// ---------------------------------------------------------------------------
// Base-58 character channel
// Valid/ready channel carrying one output character with its flags.
// ---------------------------------------------------------------------------
interface b58_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       char_last;
  logic       overflow;

  modport source (output valid, output out_char, output char_last, output overflow,
                  input ready);
  modport sink (input valid, input out_char, input char_last, input overflow,
                output ready);
endinterface

// File: hw/rtl/base58_encoder.sv
// ---------------------------------------------------------------------------
// Base-58 encoder: one byte per cycle is taken in while in the load state; after the last byte
// each digit takes one divide pass over the N stored bytes through the number RAM port.
// Output: a check state, which may emit the overflow marker, then a prefix state that emits one
// '1' per leading zero byte, then a digit RAM read state and an output state for each digit.
// Reset clears counters and sets capacity to 64; the RAMs are not cleared.
// ---------------------------------------------------------------------------
module base58_encoder #(
  parameter int unsigned MAX_BYTES  = 40,
  parameter int unsigned MAX_DIGITS = 55
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [b58_pkg::CapW-1:0] cfg_wdata_i,
  b58_in_if.sink                  byte_i,
  b58_out_if.source               char_o
);

  localparam int unsigned BIdxW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned BCntW = $clog2(MAX_BYTES + 1);
  localparam int unsigned DIdxW = $clog2(MAX_DIGITS);
  localparam int unsigned DCntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned TotW  = $clog2(MAX_BYTES + MAX_DIGITS + 1);
  localparam int unsigned CmpW  = (TotW > b58_pkg::CapW) ? TotW : b58_pkg::CapW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_CHECK,
    ST_PREFIX,
    ST_DREAD,
    ST_DOUT
  } state_e;

  state_e                       state_q;
  logic [b58_pkg::CapW-1:0]     cap_q;
  logic [BCntW-1:0]             byte_cnt_q;
  logic [BCntW-1:0]             zp_cnt_q;
  logic                         lead_zero_q;
  logic [DCntW-1:0]             dig_cnt_q;
  logic [BCntW-1:0]             iss_idx_q;
  logic [BCntW-1:0]             prc_idx_q;
  logic                         pv_q;
  logic [b58_pkg::DigitW-1:0]   rem_q;
  logic                         nz_q;
  logic                         too_long_q;
  logic [BCntW-1:0]             pre_cnt_q;
  logic [DCntW-1:0]             emit_idx_q;
  logic                         out_valid_q;
  logic [b58_pkg::CharW-1:0]    out_char_q;
  logic                         out_last_q;
  logic                         out_ovf_q;

  logic                         in_acc;
  logic                         store_byte;
  logic                         lead_zero_next;
  logic                         slot_free;
  logic                         issue;
  logic                         pass_done;

  logic                         num_we;
  logic [BIdxW-1:0]             num_waddr;
  logic [b58_pkg::ByteW-1:0]    num_wdata;
  logic [b58_pkg::ByteW-1:0]    num_rdata;
  logic                         dig_re;
  logic [b58_pkg::DigitW-1:0]   dig_rdata;

  logic [b58_pkg::CurW-1:0]     cur;
  logic [b58_pkg::ProdW-1:0]    prod;
  logic [b58_pkg::ByteW-1:0]    quot;
  logic [b58_pkg::CurW-1:0]     quot_x58;
  logic [b58_pkg::CurW-1:0]     rem_full;

  logic [CmpW-1:0]              total;
  logic                         ovf;

  assign in_acc         = byte_i.valid && byte_i.ready;
  assign store_byte     = byte_cnt_q < BCntW'(MAX_BYTES);
  assign lead_zero_next = lead_zero_q && !(store_byte && (byte_i.data_byte != '0));
  assign slot_free      = !out_valid_q || char_o.ready;
  assign issue          = (state_q == ST_DIV) && (iss_idx_q < byte_cnt_q);
  assign pass_done      = (state_q == ST_DIV) && !pv_q && (iss_idx_q == byte_cnt_q);

  assign cur      = {rem_q, num_rdata};
  assign prod     = b58_pkg::ProdW'(cur) * b58_pkg::ProdW'(b58_pkg::DivMul);
  assign quot     = prod[b58_pkg::DivShift +: b58_pkg::ByteW];
  assign quot_x58 = b58_pkg::CurW'(quot) * b58_pkg::CurW'(b58_pkg::B58Radix);
  assign rem_full = cur - quot_x58;

  always_comb begin
    num_we    = 1'b0;
    num_waddr = byte_cnt_q[BIdxW-1:0];
    num_wdata = byte_i.data_byte;
    if (state_q == ST_LOAD) begin
      num_we = in_acc && store_byte;
    end else if (state_q == ST_DIV && pv_q) begin
      num_we    = 1'b1;
      num_waddr = prc_idx_q[BIdxW-1:0];
      num_wdata = quot;
    end
  end

  assign dig_re = (state_q == ST_DREAD);

  assign total = CmpW'(zp_cnt_q) + CmpW'(dig_cnt_q);
  assign ovf   = too_long_q || (cap_q == '0) || (total >= CmpW'(cap_q)) ||
                 (total > CmpW'(MAX_DIGITS));

  b58_ram #(
    .Width (b58_pkg::ByteW),
    .Depth (MAX_BYTES),
    .AddrW (BIdxW)
  ) u_num_ram (
    .clk_i   (clk_i),
    .we_i    (num_we),
    .waddr_i (num_waddr),
    .wdata_i (num_wdata),
    .re_i    (issue),
    .raddr_i (iss_idx_q[BIdxW-1:0]),
    .rdata_o (num_rdata)
  );

  b58_ram #(
    .Width (b58_pkg::DigitW),
    .Depth (MAX_DIGITS),
    .AddrW (DIdxW)
  ) u_dig_ram (
    .clk_i   (clk_i),
    .we_i    (pass_done),
    .waddr_i (dig_cnt_q[DIdxW-1:0]),
    .wdata_i (rem_q),
    .re_i    (dig_re),
    .raddr_i (DIdxW'(emit_idx_q - DCntW'(1))),
    .rdata_o (dig_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cap_q       <= b58_pkg::CapReset;
      byte_cnt_q  <= '0;
      zp_cnt_q    <= '0;
      lead_zero_q <= 1'b1;
      dig_cnt_q   <= '0;
      iss_idx_q   <= '0;
      prc_idx_q   <= '0;
      pv_q        <= 1'b0;
      rem_q       <= '0;
      nz_q        <= 1'b0;
      too_long_q  <= 1'b0;
      pre_cnt_q   <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (out_valid_q && char_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_byte) begin
              byte_cnt_q <= byte_cnt_q + BCntW'(1);
              if (lead_zero_q && byte_i.data_byte == '0) begin
                zp_cnt_q <= zp_cnt_q + BCntW'(1);
              end
            end
            lead_zero_q <= lead_zero_next;
            if (byte_i.last_byte) begin
              iss_idx_q  <= '0;
              prc_idx_q  <= '0;
              pv_q       <= 1'b0;
              rem_q      <= '0;
              nz_q       <= 1'b0;
              dig_cnt_q  <= '0;
              too_long_q <= 1'b0;
              state_q    <= lead_zero_next ? ST_CHECK : ST_DIV;
            end
          end
        end

        ST_DIV: begin
          pv_q <= issue;
          if (issue) begin
            iss_idx_q <= iss_idx_q + BCntW'(1);
          end
          if (pv_q) begin
            prc_idx_q <= prc_idx_q + BCntW'(1);
            rem_q     <= rem_full[b58_pkg::DigitW-1:0];
            nz_q      <= nz_q || (quot != '0);
          end
          if (pass_done) begin
            dig_cnt_q <= dig_cnt_q + DCntW'(1);
            if (!nz_q) begin
              state_q <= ST_CHECK;
            end else if (dig_cnt_q >= DCntW'(MAX_DIGITS - 1)) begin
              too_long_q <= 1'b1;
              state_q    <= ST_CHECK;
            end else begin
              iss_idx_q <= '0;
              prc_idx_q <= '0;
              rem_q     <= '0;
              nz_q      <= 1'b0;
            end
          end
        end

        ST_CHECK: begin
          if (ovf) begin
            if (slot_free) begin
              out_valid_q <= 1'b1;
              out_char_q  <= b58_pkg::OvfChar;
              out_last_q  <= 1'b1;
              out_ovf_q   <= 1'b1;
              byte_cnt_q  <= '0;
              zp_cnt_q    <= '0;
              lead_zero_q <= 1'b1;
              dig_cnt_q   <= '0;
              state_q     <= ST_LOAD;
            end
          end else if (total == '0) begin
            byte_cnt_q  <= '0;
            zp_cnt_q    <= '0;
            lead_zero_q <= 1'b1;
            dig_cnt_q   <= '0;
            state_q     <= ST_LOAD;
          end else begin
            pre_cnt_q  <= zp_cnt_q;
            emit_idx_q <= dig_cnt_q;
            state_q    <= ST_PREFIX;
          end
        end

        ST_PREFIX: begin
          if (pre_cnt_q == '0) begin
            state_q <= ST_DREAD;
          end else if (slot_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= b58_pkg::b58_char('0);
            out_ovf_q   <= 1'b0;
            out_last_q  <= (pre_cnt_q == BCntW'(1)) && (emit_idx_q == '0);
            pre_cnt_q   <= pre_cnt_q - BCntW'(1);
            if ((pre_cnt_q == BCntW'(1)) && (emit_idx_q == '0)) begin
              byte_cnt_q  <= '0;
              zp_cnt_q    <= '0;
              lead_zero_q <= 1'b1;
              dig_cnt_q   <= '0;
              state_q     <= ST_LOAD;
            end
          end
        end

        ST_DREAD: begin
          state_q <= ST_DOUT;
        end

        ST_DOUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= b58_pkg::b58_char(dig_rdata);
            out_ovf_q   <= 1'b0;
            out_last_q  <= (emit_idx_q == DCntW'(1));
            emit_idx_q  <= emit_idx_q - DCntW'(1);
            if (emit_idx_q == DCntW'(1)) begin
              byte_cnt_q  <= '0;
              zp_cnt_q    <= '0;
              lead_zero_q <= 1'b1;
              dig_cnt_q   <= '0;
              state_q     <= ST_LOAD;
            end else begin
              state_q <= ST_DREAD;
            end
          end
        end

        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign byte_i.ready     = (state_q == ST_LOAD);
  assign char_o.valid     = out_valid_q;
  assign char_o.out_char  = out_char_q;
  assign char_o.char_last = out_last_q;
  assign char_o.overflow  = out_ovf_q;

endmodule

// File: hw/rtl/b58_ram.sv
// ---------------------------------------------------------------------------
// Base-58 generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module b58_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 40,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/b58_checker.sv
// ---------------------------------------------------------------------------
// Base-58 encoder checker
// Port-level assertions on the encoder, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "base58_encoder_defines.svh"

module b58_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       out_last,
  input logic       out_overflow
);

  `B58_ASSERT_IMP(a_ovf_form, clk_i, rst_ni, out_valid && out_overflow, out_last && (out_char == 7'd0))
  `B58_ASSERT_IMP(a_char_nonzero, clk_i, rst_ni, out_valid && !out_overflow, out_char != 7'd0)
  `B58_ASSERT_NXT(a_last_stalls_input, clk_i, rst_ni, in_valid && in_ready && in_last, !in_ready)
  `B58_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_char))

endmodule

bind base58_encoder b58_checker u_b58_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (byte_i.valid),
  .in_ready     (byte_i.ready),
  .in_last      (byte_i.last_byte),
  .out_valid    (char_o.valid),
  .out_ready    (char_o.ready),
  .out_char     (char_o.out_char),
  .out_last     (char_o.char_last),
  .out_overflow (char_o.overflow)
);
